/* hdl/mau_pkg.sv */
// ----------------------------------------------------------------------------
// mau_pkg
// shared types and codes for the modular arithmetic unit
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int unsigned MW = 31;
  localparam int unsigned DW = 64;
  localparam logic [MW-1:0] MOD_RESET = 31'd1000000007;

  localparam logic [3:0] CMD_REDUCE = 4'd0;
  localparam logic [3:0] CMD_ADD    = 4'd1;
  localparam logic [3:0] CMD_SUB    = 4'd2;
  localparam logic [3:0] CMD_NEG    = 4'd3;
  localparam logic [3:0] CMD_MUL    = 4'd4;
  localparam logic [3:0] CMD_DIV    = 4'd5;
  localparam logic [3:0] CMD_POW    = 4'd6;
  localparam logic [3:0] CMD_CHOOSE = 4'd7;
  localparam logic [3:0] CMD_CMP    = 4'd8;

  typedef struct packed {
    logic [3:0]           cmd;
    logic signed [DW-1:0] operand_a;
    logic signed [DW-1:0] operand_b;
  } mau_in_t;

  typedef struct packed {
    logic [MW-1:0] residue;
    logic          equal;
  } mau_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RA, S_RB, S_DISP, S_MUL, S_PCHK, S_PACC, S_PSQ, S_FIN,
    S_CSET, S_CCHK, S_CFN, S_CNU, S_CFD, S_CDE
  } mau_state_t;

endpackage

/* hdl/mau_red.sv */
// ----------------------------------------------------------------------------
// mau_red
// bit-serial restoring reducer: 64-bit value modulo a 31-bit modulus
// ----------------------------------------------------------------------------
module mau_red (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [63:0]           val,
  input  logic [mau_pkg::MW-1:0] m,
  output logic                  done,
  output logic [mau_pkg::MW-1:0] rem
);
  import mau_pkg::*;

  logic [DW-1:0] sh_r, sh_nxt;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [MW:0]   t;

  always_comb begin
    t        = {rem_r, sh_r[DW-1]};
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (go) begin
      sh_nxt  = val;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      if (t >= {1'b0, m}) t = t - {1'b0, m};
      rem_nxt  = t[MW-1:0];
      sh_nxt   = {sh_r[DW-2:0], 1'b0};
      cnt_nxt  = cnt_r - 7'd1;
      done_nxt = (cnt_r == 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* hdl/modular_arithmetic_unit_top.sv */
// ----------------------------------------------------------------------------
// modular_arithmetic_unit_top
// modular arithmetic over a register-held modulus, one shared reducer
// ----------------------------------------------------------------------------
// sequence: each 64-bit reduction or multiply-reduce runs on the shared serial
// reducer; reduce/add/sub/negate/compare take two reductions (one per operand),
// multiply three, power up to 130 reductions and divide up to 65, choose four
// reductions per step of r plus the inverse
// throughput: one item at a time, busy high until the result strobe
// reset: synchronous active-low, modulus returns to 1000000007
module modular_arithmetic_unit_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mau_pkg::mau_in_t     in_data,
  output logic                 out_valid,
  output mau_pkg::mau_out_t    out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [mau_pkg::MW-1:0] cfg_data
);
  import mau_pkg::*;

  mau_state_t    state_r, state_nxt;
  logic          ph_r, ph_nxt;
  logic [MW-1:0] mod_r;
  logic [3:0]    cmd_r, cmd_nxt;
  logic [DW-1:0] ain_r, ain_nxt, bin_r, bin_nxt, e_r, e_nxt;
  logic [MW-1:0] m_r, m_nxt, a_r, a_nxt, b_r, b_nxt, acc_r, acc_nxt;
  logic [MW-1:0] base_r, base_nxt, nu_r, nu_nxt, de_r, de_nxt, tmp_r, tmp_nxt;
  logic [31:0]   i_r, i_nxt, rc_r, rc_nxt, n_r, n_nxt;
  logic          ov_r, ov_nxt;
  mau_out_t      od_r, od_nxt;

  logic          red_go, red_done;
  logic [DW-1:0] red_val;
  logic [MW-1:0] red_rem, mx, my, one, fold;
  logic [2*MW-1:0] prod;
  logic [MW:0]   s;
  logic signed [32:0] nx, rx, dd, rr;

  mau_red u_red (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (red_go),
    .val  (red_val),
    .m    (m_r),
    .done (red_done),
    .rem  (red_rem)
  );

  assign prod = mx * my;
  assign one  = (m_r == 31'd1) ? 31'd0 : 31'd1;

  always_comb begin
    mx = '0;
    my = '0;
    unique case (state_r)
      S_MUL:  begin mx = a_r;    my = b_r;    end
      S_PACC: begin mx = acc_r;  my = base_r; end
      S_PSQ:  begin mx = base_r; my = base_r; end
      S_FIN:  begin mx = (cmd_r == CMD_DIV) ? a_r : nu_r; my = acc_r; end
      S_CNU:  begin mx = nu_r;   my = tmp_r;  end
      S_CDE:  begin mx = de_r;   my = tmp_r;  end
      default: ;
    endcase
  end

  always_comb begin
    unique case (state_r)
      S_RA:    red_val = ain_r[DW-1] ? (~ain_r + 64'd1) : ain_r;
      S_RB:    red_val = bin_r[DW-1] ? (~bin_r + 64'd1) : bin_r;
      S_CFN:   red_val = {32'd0, n_r - i_r};
      S_CFD:   red_val = {32'd0, i_r + 32'd1};
      default: red_val = {2'd0, prod};
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt = ph_r;
    cmd_nxt = cmd_r; ain_nxt = ain_r; bin_nxt = bin_r; e_nxt = e_r;
    m_nxt = m_r; a_nxt = a_r; b_nxt = b_r; acc_nxt = acc_r; base_nxt = base_r;
    nu_nxt = nu_r; de_nxt = de_r; tmp_nxt = tmp_r;
    i_nxt = i_r; rc_nxt = rc_r; n_nxt = n_r;
    ov_nxt = 1'b0;
    od_nxt = od_r;
    red_go = 1'b0;
    s  = '0;
    nx = '0; rx = '0; dd = '0; rr = '0;
    fold = red_rem;
    if (ph_r == 1'b0) begin
      if (state_r == S_RA || state_r == S_RB || state_r == S_MUL ||
          state_r == S_PACC || state_r == S_PSQ || state_r == S_FIN ||
          state_r == S_CFN || state_r == S_CNU || state_r == S_CFD ||
          state_r == S_CDE) begin
        red_go = 1'b1;
        ph_nxt = 1'b1;
      end
    end
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_data.cmd;
          ain_nxt   = in_data.operand_a;
          bin_nxt   = in_data.operand_b;
          m_nxt     = (mod_r < 31'd2) ? 31'd1 : mod_r;
          ph_nxt    = 1'b0;
          state_nxt = S_RA;
        end
      end
      S_RA: if (ph_r && red_done) begin
        if (ain_r[DW-1] && red_rem != '0) fold = m_r - red_rem;
        a_nxt = fold; ph_nxt = 1'b0; state_nxt = S_RB;
      end
      S_RB: if (ph_r && red_done) begin
        if (bin_r[DW-1] && red_rem != '0) fold = m_r - red_rem;
        b_nxt = fold; ph_nxt = 1'b0; state_nxt = S_DISP;
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        od_nxt    = '0;
        case (cmd_r)
          CMD_REDUCE: begin od_nxt.residue = a_r; ov_nxt = 1'b1; end
          CMD_ADD: begin
            s = {1'b0, a_r} + {1'b0, b_r};
            if (s >= {1'b0, m_r}) s = s - {1'b0, m_r};
            od_nxt.residue = s[MW-1:0]; ov_nxt = 1'b1;
          end
          CMD_SUB: begin
            s = (a_r >= b_r) ? ({1'b0, a_r} - {1'b0, b_r})
                             : ({1'b0, a_r} + {1'b0, m_r} - {1'b0, b_r});
            od_nxt.residue = s[MW-1:0]; ov_nxt = 1'b1;
          end
          CMD_NEG: begin
            od_nxt.residue = (a_r == '0) ? '0 : m_r - a_r; ov_nxt = 1'b1;
          end
          CMD_CMP: begin od_nxt.equal = (a_r == b_r); ov_nxt = 1'b1; end
          CMD_MUL: state_nxt = S_MUL;
          CMD_DIV: begin
            base_nxt = b_r; acc_nxt = one;
            e_nxt = {33'd0, m_r} - 64'd2; state_nxt = S_PCHK;
          end
          CMD_POW: begin
            base_nxt = a_r; acc_nxt = one; e_nxt = bin_r; state_nxt = S_PCHK;
          end
          CMD_CHOOSE: state_nxt = S_CSET;
          default: ov_nxt = 1'b1;
        endcase
      end
      S_MUL: if (ph_r && red_done) begin
        od_nxt = '0; od_nxt.residue = red_rem; ov_nxt = 1'b1;
        ph_nxt = 1'b0; state_nxt = S_IDLE;
      end
      S_PCHK: begin
        if (e_r == '0) begin
          if (cmd_r == CMD_POW) begin
            od_nxt = '0; od_nxt.residue = acc_r; ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          state_nxt = e_r[0] ? S_PACC : S_PSQ;
        end
      end
      S_PACC: if (ph_r && red_done) begin
        acc_nxt = red_rem; ph_nxt = 1'b0; state_nxt = S_PSQ;
      end
      S_PSQ: if (ph_r && red_done) begin
        base_nxt = red_rem; e_nxt = {1'b0, e_r[DW-1:1]};
        ph_nxt = 1'b0; state_nxt = S_PCHK;
      end
      S_FIN: if (ph_r && red_done) begin
        od_nxt = '0; od_nxt.residue = red_rem; ov_nxt = 1'b1;
        ph_nxt = 1'b0; state_nxt = S_IDLE;
      end
      S_CSET: begin
        nx = {ain_r[31], ain_r[31:0]};
        rx = {bin_r[31], bin_r[31:0]};
        dd = nx - rx;
        rr = (dd < rx) ? dd : rx;
        if (rr < 0) begin
          od_nxt = '0; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          rc_nxt = rr[31:0]; n_nxt = ain_r[31:0]; i_nxt = '0;
          nu_nxt = one; de_nxt = one; state_nxt = S_CCHK;
        end
      end
      S_CCHK: begin
        if (i_r == rc_r) begin
          base_nxt = de_r; acc_nxt = one;
          e_nxt = {33'd0, m_r} - 64'd2; state_nxt = S_PCHK;
        end else begin
          state_nxt = S_CFN;
        end
      end
      S_CFN: if (ph_r && red_done) begin
        tmp_nxt = red_rem; ph_nxt = 1'b0; state_nxt = S_CNU;
      end
      S_CNU: if (ph_r && red_done) begin
        ph_nxt = 1'b0;
        if (red_rem == '0) begin
          od_nxt = '0; ov_nxt = 1'b1; state_nxt = S_IDLE;
        end else begin
          nu_nxt = red_rem; state_nxt = S_CFD;
        end
      end
      S_CFD: if (ph_r && red_done) begin
        tmp_nxt = red_rem; ph_nxt = 1'b0; state_nxt = S_CDE;
      end
      S_CDE: if (ph_r && red_done) begin
        de_nxt = red_rem; i_nxt = i_r + 32'd1;
        ph_nxt = 1'b0; state_nxt = S_CCHK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= 1'b0;
      ov_r    <= 1'b0;
      mod_r   <= MOD_RESET;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) mod_r <= cfg_data;
    end
    cmd_r <= cmd_nxt; ain_r <= ain_nxt; bin_r <= bin_nxt; e_r <= e_nxt;
    m_r <= m_nxt; a_r <= a_nxt; b_r <= b_nxt; acc_r <= acc_nxt;
    base_r <= base_nxt; nu_r <= nu_nxt; de_r <= de_nxt; tmp_r <= tmp_nxt;
    i_r <= i_nxt; rc_r <= rc_nxt; n_r <= n_nxt; od_r <= od_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

/* hdl/mau_chk.sv */
// ----------------------------------------------------------------------------
// mau_chk
// port-level checks for the modular arithmetic unit
// ----------------------------------------------------------------------------
module mau_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input mau_pkg::mau_out_t out_data
);
  import mau_pkg::*;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("busy dropped without a result");

  a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.equal) |-> (out_data.residue == '0))
    else $error("compare result with nonzero residue");

endmodule

bind modular_arithmetic_unit_top mau_chk u_mau_chk (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_data (out_data)
);
